/* rtl/cia_pkg.sv */
// Shared types, codes and constants of the compact-ISA ALU execute block.
package cia_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned INSN_W   = 16;
  localparam int unsigned FLAGS_W  = 4;
  localparam int unsigned REGIDX_W = 3;
  localparam int unsigned SHAMT_W  = 8;

  // Flag bit positions in flags_in / flags_out
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned REQ_BITS  = INSN_W + 2 * XLEN + FLAGS_W;
  localparam int unsigned REQ_TDATA = ((REQ_BITS + 7) / 8) * 8;
  localparam int unsigned RES_BITS  = 2 + REGIDX_W + XLEN + FLAGS_W;
  localparam int unsigned RES_TDATA = ((RES_BITS + 7) / 8) * 8;

  // Format selectors
  localparam logic [2:0] FMT_SHIFT_ADDSUB = 3'b000;
  localparam logic [2:0] FMT_IMM8         = 3'b001;
  localparam logic [5:0] FMT_ALU          = 6'b010000;
  localparam logic [1:0] SUBOP_ADDSUB     = 2'b11;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } cia_shkind_e;

  typedef enum logic [1:0] {
    IMM_MOV = 2'd0,
    IMM_CMP = 2'd1,
    IMM_ADD = 2'd2,
    IMM_SUB = 2'd3
  } cia_immop_e;

  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_LSL = 4'h2,
    OP_LSR = 4'h3,
    OP_ASR = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_ROR = 4'h7,
    OP_TST = 4'h8,
    OP_NEG = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MUL = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } cia_aluop_e;

  typedef struct packed {
    cia_shkind_e        kind;
    logic [SHAMT_W-1:0] amount;
  } cia_shctl_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [XLEN-1:0]    second;
    logic [XLEN-1:0]    first;
    logic [INSN_W-1:0]  insn;
  } cia_req_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]  flags;
    logic [XLEN-1:0]     value;
    logic [REGIDX_W-1:0] rd;
    logic                we;
    logic                handled;
  } cia_res_t;

endpackage

/* rtl/compact_isa_alu_execute.sv */
// Top level: request register, single-pass execute and result register.
//
//  Channel  | Direction | Handshake              | Payload (low bits first)
//  ---------+-----------+------------------------+---------------------------------------
//  s_       | in        | s_tvalid_i / s_tready_o | instruction, first_value, second_value,
//           |           |                        | flags_in (88-bit tdata)
//  m_       | out       | m_tvalid_o / m_tready_i | handled, write_enable, dest_index,
//           |           |                        | result_value, flags_out (48-bit tdata)
//
// Requests pass the request then result register; one is taken every cycle unless stalled.
// Execute is one pass of decode, a 33-bit adder, a 32x32 low-word multiplier and
// a barrel shifter between the request and result registers.
// Reset empties both registers; no clearing pass is needed.
// A stalled result holds both stages; s_tready_o stays high while either has room.
module compact_isa_alu_execute import cia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  // instruction[15:0], first_value[47:16], second_value[79:48], flags_in[83:80], zero pad
  input  logic [REQ_TDATA-1:0] s_tdata_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  // handled[0], write_enable[1], dest_index[4:2], result_value[36:5], flags_out[40:37], pad
  output logic [RES_TDATA-1:0] m_tdata_o
);

  cia_req_t req_q;
  logic     req_vld_q;
  logic     req_vld_d;
  cia_res_t res_q;
  cia_res_t res_d;
  logic     res_vld_q;
  logic     res_vld_d;
  logic     res_ready;
  logic     req_ready;
  logic     req_load;
  logic     res_load;

  assign res_ready  = !res_vld_q || m_tready_i;
  assign req_ready  = !req_vld_q || res_ready;
  assign s_tready_o = req_ready;
  assign req_load   = s_tvalid_i && req_ready;
  assign res_load   = req_vld_q && res_ready;

  assign req_vld_d = req_ready ? s_tvalid_i : req_vld_q;
  assign res_vld_d = res_ready ? req_vld_q : res_vld_q;

  cia_alu u_alu (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) req_q <= cia_req_t'(s_tdata_i[REQ_BITS-1:0]);
    if (res_load) res_q <= res_d;
  end

  assign m_tvalid_o = res_vld_q;
  assign m_tdata_o  = RES_TDATA'(res_q);

  // Assertions
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> req_vld_q)
    else $error("accepted request not held in request register");

  a_stall_holds_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && !res_ready) |=> req_vld_q)
    else $error("request lost while result stage stalled");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && res_ready) |=> res_vld_q)
    else $error("request did not advance to result register");

  a_unhandled_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !res_q.handled) |-> (!res_q.we && (res_q.value == '0)))
    else $error("unhandled instruction produced a write");

endmodule

/* rtl/cia_shift.sv */
// Barrel shifter with architectural carry-out for LSL, LSR, ASR and ROR.
module cia_shift import cia_pkg::*; (
  input  logic [XLEN-1:0] value_i,
  input  cia_shctl_t      ctl_i,
  output logic [XLEN-1:0] result_o,
  output logic            carry_o,
  output logic            carry_upd_o
);

  logic [4:0]      amt5;
  logic            amt_zero;
  logic            amt_big;
  logic            amt_32;
  logic [XLEN:0]   lsl_w;
  logic [XLEN:0]   lsr_w;
  logic [XLEN:0]   asr_w;
  logic [XLEN-1:0] rot;

  assign amt5     = ctl_i.amount[4:0];
  assign amt_zero = (ctl_i.amount == '0);
  assign amt_big  = |ctl_i.amount[SHAMT_W-1:5];
  assign amt_32   = (ctl_i.amount == SHAMT_W'(XLEN));

  // carry rides in the extra bit next to the word
  assign lsl_w = {1'b0, value_i} << amt5;
  assign lsr_w = {value_i, 1'b0} >> amt5;
  assign asr_w = $unsigned($signed({value_i, 1'b0}) >>> amt5);
  assign rot   = XLEN'({value_i, value_i} >> amt5);

  always_comb begin
    result_o    = value_i;
    carry_o     = 1'b0;
    carry_upd_o = 1'b0;
    if (!amt_zero) begin
      carry_upd_o = 1'b1;
      unique case (ctl_i.kind)
        SH_LSL: begin
          if (!amt_big) begin
            result_o = lsl_w[XLEN-1:0];
            carry_o  = lsl_w[XLEN];
          end else begin
            result_o = '0;
            carry_o  = amt_32 & value_i[0];
          end
        end
        SH_LSR: begin
          if (!amt_big) begin
            result_o = lsr_w[XLEN:1];
            carry_o  = lsr_w[0];
          end else begin
            result_o = '0;
            carry_o  = amt_32 & value_i[XLEN-1];
          end
        end
        SH_ASR: begin
          if (!amt_big) begin
            result_o = asr_w[XLEN:1];
            carry_o  = asr_w[0];
          end else begin
            result_o = {XLEN{value_i[XLEN-1]}};
            carry_o  = value_i[XLEN-1];
          end
        end
        SH_ROR: begin
          // a multiple of 32 leaves the word and takes carry from bit 31
          result_o = rot;
          carry_o  = rot[XLEN-1];
        end
        default: begin
          result_o = value_i;
        end
      endcase
    end
  end

endmodule

/* rtl/cia_alu.sv */
// Decode and single-pass execute of one data-processing instruction.
module cia_alu import cia_pkg::*; (
  input  cia_req_t req_i,
  output cia_res_t res_o
);

  logic [INSN_W-1:0]  insn;
  logic [XLEN-1:0]    opa;
  logic [XLEN-1:0]    opb;
  logic [FLAGS_W-1:0] flg;

  logic is_addsub;
  logic is_shift;
  logic is_imm;
  logic is_alu;

  cia_shctl_t      sh_ctl;
  logic [XLEN-1:0] sh_res;
  logic            sh_c;
  logic            sh_cupd;

  logic [XLEN-1:0] add_x;
  logic [XLEN-1:0] add_y;
  logic            add_cin;
  logic [XLEN:0]   add_sum;
  logic [XLEN-1:0] add_res;
  logic            add_v;
  logic [XLEN-1:0] mul_res;

  logic [4:0]  imm5;
  logic [XLEN-1:0] imm8;
  logic [XLEN-1:0] imm3;
  cia_aluop_e  alu_op;
  cia_immop_e  imm_op;
  cia_shkind_e sh_kind_imm;

  assign insn = req_i.insn;
  assign opa  = req_i.first;
  assign opb  = req_i.second;
  assign flg  = req_i.flags;

  assign is_addsub = (insn[15:13] == FMT_SHIFT_ADDSUB) && (insn[12:11] == SUBOP_ADDSUB);
  assign is_shift  = (insn[15:13] == FMT_SHIFT_ADDSUB) && (insn[12:11] != SUBOP_ADDSUB);
  assign is_imm    = (insn[15:13] == FMT_IMM8);
  assign is_alu    = (insn[15:10] == FMT_ALU);

  assign imm5        = insn[10:6];
  assign imm8        = XLEN'(insn[7:0]);
  assign imm3        = XLEN'(insn[8:6]);
  assign alu_op      = cia_aluop_e'(insn[9:6]);
  assign imm_op      = cia_immop_e'(insn[12:11]);
  assign sh_kind_imm = cia_shkind_e'(insn[12:11]);

  // Shifter control: immediate LSR/ASR of zero encode a shift by 32
  always_comb begin
    sh_ctl.kind   = SH_LSL;
    sh_ctl.amount = opb[SHAMT_W-1:0];
    if (is_shift) begin
      sh_ctl.kind = sh_kind_imm;
      if ((imm5 == '0) && (sh_kind_imm != SH_LSL)) begin
        sh_ctl.amount = SHAMT_W'(XLEN);
      end else begin
        sh_ctl.amount = SHAMT_W'(imm5);
      end
    end else begin
      unique case (alu_op)
        OP_LSR:  sh_ctl.kind = SH_LSR;
        OP_ASR:  sh_ctl.kind = SH_ASR;
        OP_ROR:  sh_ctl.kind = SH_ROR;
        default: sh_ctl.kind = SH_LSL;
      endcase
    end
  end

  cia_shift u_shift (
    .value_i     (opa),
    .ctl_i       (sh_ctl),
    .result_o    (sh_res),
    .carry_o     (sh_c),
    .carry_upd_o (sh_cupd)
  );

  // Adder operand select: subtraction is x + ~y + carry-in
  always_comb begin
    add_x   = opa;
    add_y   = opb;
    add_cin = 1'b0;
    if (is_addsub) begin
      add_y   = insn[10] ? imm3 : opb;
      if (insn[9]) begin
        add_y   = ~add_y;
        add_cin = 1'b1;
      end
    end else if (is_imm) begin
      add_y = imm8;
      if ((imm_op == IMM_CMP) || (imm_op == IMM_SUB)) begin
        add_y   = ~imm8;
        add_cin = 1'b1;
      end
    end else begin
      unique case (alu_op)
        OP_ADC: add_cin = flg[FLAG_C];
        OP_SBC: begin
          add_y   = ~opb;
          add_cin = flg[FLAG_C];
        end
        OP_NEG: begin
          add_x   = '0;
          add_y   = ~opb;
          add_cin = 1'b1;
        end
        OP_CMP: begin
          add_y   = ~opb;
          add_cin = 1'b1;
        end
        default: add_cin = 1'b0;
      endcase
    end
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + (XLEN+1)'(add_cin);
  assign add_res = add_sum[XLEN-1:0];
  assign add_v   = (add_x[XLEN-1] == add_y[XLEN-1]) && (add_res[XLEN-1] != add_x[XLEN-1]);
  assign mul_res = opa * opb;

  always_comb begin
    res_o.handled = 1'b1;
    res_o.we      = 1'b1;
    res_o.rd      = insn[2:0];
    res_o.value   = add_res;
    res_o.flags   = flg;
    if (is_addsub) begin
      res_o.flags = {add_res[XLEN-1], add_res == '0, add_sum[XLEN], add_v};
    end else if (is_shift) begin
      res_o.value        = sh_res;
      res_o.flags[FLAG_N] = sh_res[XLEN-1];
      res_o.flags[FLAG_Z] = (sh_res == '0);
      if (sh_cupd) res_o.flags[FLAG_C] = sh_c;
    end else if (is_imm) begin
      res_o.rd = insn[10:8];
      if (imm_op == IMM_MOV) begin
        res_o.value         = imm8;
        res_o.flags[FLAG_N] = 1'b0;
        res_o.flags[FLAG_Z] = (imm8 == '0);
      end else begin
        res_o.we    = (imm_op != IMM_CMP);
        res_o.flags = {add_res[XLEN-1], add_res == '0, add_sum[XLEN], add_v};
      end
    end else if (is_alu) begin
      unique case (alu_op)
        OP_AND, OP_TST: res_o.value = opa & opb;
        OP_EOR:         res_o.value = opa ^ opb;
        OP_ORR:         res_o.value = opa | opb;
        OP_BIC:         res_o.value = opa & ~opb;
        OP_MVN:         res_o.value = ~opb;
        OP_MUL:         res_o.value = mul_res;
        OP_LSL, OP_LSR, OP_ASR, OP_ROR: res_o.value = sh_res;
        default:        res_o.value = add_res;
      endcase
      res_o.we = !((alu_op == OP_TST) || (alu_op == OP_CMP) || (alu_op == OP_CMN));
      res_o.flags[FLAG_N] = res_o.value[XLEN-1];
      res_o.flags[FLAG_Z] = (res_o.value == '0);
      unique case (alu_op)
        OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
          res_o.flags[FLAG_C] = add_sum[XLEN];
          res_o.flags[FLAG_V] = add_v;
        end
        OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
          if (sh_cupd) res_o.flags[FLAG_C] = sh_c;
        end
        OP_MUL:  res_o.flags[FLAG_C] = 1'b0;
        default: res_o.flags[FLAG_C] = flg[FLAG_C];
      endcase
    end else begin
      // drop: not one of the four formats
      res_o.handled = 1'b0;
      res_o.we      = 1'b0;
      res_o.rd      = '0;
      res_o.value   = '0;
    end
  end

endmodule
